FILE: design/mss_pkg.sv
package mss_pkg;

	localparam int STRAIN_W   = 32;
	localparam int MOD_W      = 32;
	localparam int BRK_W      = 31;
	localparam int MAGX_W     = (STRAIN_W > BRK_W) ? STRAIN_W : BRK_W + 1;
	localparam int OP_W       = MAGX_W + 1;
	localparam int PROD_W     = MOD_W + OP_W + 1;
	localparam int SUM_W      = PROD_W + 2;
	localparam int STRESS_W   = 64;
	localparam int TAN_W      = 32;
	localparam int SEG_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int Q_CW       = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_INITIAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_FIRST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_SECOND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_SECOND  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THIRD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BREAK_THIRD   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LAST    = 3'd6;

	localparam logic [SEG_W-1:0] SEG_INITIAL = 2'd0;
	localparam logic [SEG_W-1:0] SEG_SECOND  = 2'd1;
	localparam logic [SEG_W-1:0] SEG_THIRD   = 2'd2;
	localparam logic [SEG_W-1:0] SEG_LAST    = 2'd3;

	localparam logic [MOD_W-1:0] SLOPE_RST        = MOD_W'(1);
	localparam logic [BRK_W-1:0] BREAK_FIRST_RST  = BRK_W'(6553600);
	localparam logic [BRK_W-1:0] BREAK_SECOND_RST = BRK_W'(13107200);
	localparam logic [BRK_W-1:0] BREAK_THIRD_RST  = BRK_W'(19660800);

	localparam logic signed [STRESS_W-1:0] STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
	localparam logic signed [STRESS_W-1:0] STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

	typedef logic        [MOD_W-1:0]  slope_t;
	typedef logic        [BRK_W-1:0]  brk_t;
	typedef logic        [MAGX_W-1:0] magx_t;
	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		slope_t slope_initial;
		brk_t   break_first;
		slope_t slope_second;
		brk_t   break_second;
		slope_t slope_third;
		brk_t   break_third;
		slope_t slope_last;
	} cfg_t;

	// one classified sample: multiplier operands per segment lane
	typedef struct packed {
		op_t              op0;
		op_t              op1;
		op_t              op2;
		op_t              op3;
		logic [SEG_W-1:0] seg;
		logic             neg;
		logic             zero;
	} qentry_t;

	typedef struct packed {
		logic [TAN_W-1:0] tangent;
		logic [SEG_W-1:0] seg;
		logic             neg;
		logic             zero;
	} side_t;

	function automatic prod_t mul_slope(input slope_t s, input op_t o);
		prod_t a;
		prod_t b;
		a = prod_t'($signed({1'b0, s}));
		b = prod_t'(o);
		return a * b;
	endfunction

endpackage

FILE: design/mss_intf.sv
interface mss_in_if;
	import mss_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [STRAIN_W-1:0] strain;
	modport source (output valid, output strain, input ready);
	modport sink   (input valid, input strain, output ready);
endinterface

interface mss_out_if;
	import mss_pkg::*;
	logic                       valid;
	logic                       ready;
	logic        [TAN_W-1:0]    tangent_modulus;
	logic signed [STRESS_W-1:0] stress;
	logic        [SEG_W-1:0]    segment;
	logic                       overflow;
	modport source (output valid, output tangent_modulus, output stress, output segment,
		output overflow, input ready);
	modport sink   (input valid, input tangent_modulus, input stress, input segment,
		input overflow, output ready);
endinterface

interface mss_cfg_if;
	import mss_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/multilinear_stress_strain_core.sv
// channel   modport  beat
// sample    sink     strain, Q16.16 signed
// result    source   tangent_modulus, stress Q48.16, segment, overflow
// cfg       sink     index (0..6, higher ignored), data
//
// One sample per cycle while a full queue does not stall the front. A result passes through
// the front register, classify into the queue, multiply, two add stages and the saturating
// output register.
// Reset clears valid bits and pointers and loads the register defaults.
// A stalled result freezes the back pipeline; the four-entry queue keeps the front
// accepting until it fills. cfg is always ready.
module multilinear_stress_strain_core (
	input  logic     clk,
	input  logic     arst_n,
	mss_in_if.sink   sample,
	mss_out_if.source result,
	mss_cfg_if.sink  cfg
);
	import mss_pkg::*;

	cfg_t    regs;
	qentry_t push_data;
	qentry_t pop_data;
	logic    push_valid;
	logic    push_ready;
	logic    pop_valid;
	logic    pop_ready;

	mss_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.regs       (regs),
		.push_data  (push_data),
		.push_ready (push_ready),
		.push_valid (push_valid)
	);

	mss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	mss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.regs      (regs),
		.result    (result)
	);

	a_ovf_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.overflow |->
			(result.stress == STRESS_MAX) || (result.stress == STRESS_MIN))
		else $error("saturated stress not at a limit");

	a_tangent: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			((result.segment == SEG_INITIAL) && (result.tangent_modulus == regs.slope_initial)) ||
			((result.segment == SEG_SECOND) && (result.tangent_modulus == regs.slope_second)) ||
			((result.segment == SEG_THIRD) && (result.tangent_modulus == regs.slope_third)) ||
			((result.segment == SEG_LAST) && (result.tangent_modulus == regs.slope_last)))
		else $error("tangent does not match segment slope");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid)
		else $error("classified sample dropped while queue full");

endmodule

FILE: design/mss_regs.sv
module mss_regs (
	input  logic          clk,
	input  logic          arst_n,
	mss_cfg_if.sink       cfg,
	output mss_pkg::cfg_t regs
);
	import mss_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.slope_initial <= SLOPE_RST;
			regs_q.break_first   <= BREAK_FIRST_RST;
			regs_q.slope_second  <= SLOPE_RST;
			regs_q.break_second  <= BREAK_SECOND_RST;
			regs_q.slope_third   <= SLOPE_RST;
			regs_q.break_third   <= BREAK_THIRD_RST;
			regs_q.slope_last    <= SLOPE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SLOPE_INITIAL: regs_q.slope_initial <= cfg.data[MOD_W-1:0];
				REG_BREAK_FIRST:   regs_q.break_first   <= cfg.data[BRK_W-1:0];
				REG_SLOPE_SECOND:  regs_q.slope_second  <= cfg.data[MOD_W-1:0];
				REG_BREAK_SECOND:  regs_q.break_second  <= cfg.data[BRK_W-1:0];
				REG_SLOPE_THIRD:   regs_q.slope_third   <= cfg.data[MOD_W-1:0];
				REG_BREAK_THIRD:   regs_q.break_third   <= cfg.data[BRK_W-1:0];
				REG_SLOPE_LAST:    regs_q.slope_last    <= cfg.data[MOD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: design/mss_front.sv
module mss_front (
	input  logic             clk,
	input  logic             arst_n,
	mss_in_if.sink           sample,
	input  mss_pkg::cfg_t    regs,
	output mss_pkg::qentry_t push_data,
	input  logic             push_ready,
	output logic             push_valid
);
	import mss_pkg::*;

	logic                v_s1;
	logic [STRAIN_W-1:0] mag_s1;
	logic                neg_s1;

	logic [STRAIN_W-1:0] x;
	magx_t               mag_e;
	magx_t               b1;
	magx_t               b2;
	magx_t               b3;
	magx_t               base;
	op_t                 excess;
	op_t                 d21;
	op_t                 d32;
	logic [SEG_W-1:0]    seg;

	assign x            = sample.strain;
	assign sample.ready = !v_s1 || push_ready;
	assign push_valid   = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	// magnitude of the most negative code is held exactly as unsigned
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			neg_s1 <= x[STRAIN_W-1];
			mag_s1 <= x[STRAIN_W-1] ? (~x + STRAIN_W'(1)) : x;
		end
	end

	always_comb begin
		mag_e = MAGX_W'(mag_s1);
		b1    = MAGX_W'(regs.break_first);
		b2    = MAGX_W'(regs.break_second);
		b3    = MAGX_W'(regs.break_third);
		d21   = op_t'(b2) - op_t'(b1);
		d32   = op_t'(b3) - op_t'(b2);
		if (mag_e < b1) begin
			seg = SEG_INITIAL;
		end else if (mag_e < b2) begin
			seg = SEG_SECOND;
		end else if (mag_e < b3) begin
			seg = SEG_THIRD;
		end else begin
			seg = SEG_LAST;
		end
		case (seg)
			SEG_INITIAL: base = '0;
			SEG_SECOND:  base = b1;
			SEG_THIRD:   base = b2;
			default:     base = b3;
		endcase
		excess = op_t'(mag_e) - op_t'(base);

		push_data.seg  = seg;
		push_data.neg  = neg_s1;
		push_data.zero = (mag_s1 == '0);
		push_data.op0  = op_t'(b1);
		push_data.op1  = '0;
		push_data.op2  = '0;
		push_data.op3  = '0;
		case (seg)
			SEG_INITIAL: begin
				push_data.op0 = excess;
			end
			SEG_SECOND: begin
				push_data.op1 = excess;
			end
			SEG_THIRD: begin
				push_data.op1 = d21;
				push_data.op2 = excess;
			end
			default: begin
				push_data.op1 = d21;
				push_data.op2 = d32;
				push_data.op3 = excess;
			end
		endcase
	end

endmodule

FILE: design/mss_queue.sv
module mss_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  mss_pkg::qentry_t push_data,
	input  logic             push_valid,
	output logic             push_ready,
	output mss_pkg::qentry_t pop_data,
	output logic             pop_valid,
	input  logic             pop_ready
);
	import mss_pkg::*;

	qentry_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (cnt_q != Q_CW'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + Q_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + Q_CW'(1);
				2'b01:   cnt_q <= cnt_q - Q_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: design/mss_back.sv
module mss_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mss_pkg::qentry_t pop_data,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  mss_pkg::cfg_t    regs,
	mss_out_if.source        result
);
	import mss_pkg::*;

	logic  en;
	logic  v_s1, v_s2, v_s3, v_s4;
	side_t side_s1, side_s2, side_s3;
	prod_t p0_s1, p1_s1, p2_s1, p3_s1;
	sum_t  pa_s2, pb_s2;
	sum_t  tot_s3;

	logic [TAN_W-1:0] tan_s4;
	logic [SEG_W-1:0] seg_s4;
	logic             ovf_s4;
	logic signed [STRESS_W-1:0] stress_s4;

	slope_t tan_sel;
	sum_t   val;
	logic   fits;

	assign en        = !v_s4 || result.ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		case (pop_data.seg)
			SEG_INITIAL: tan_sel = regs.slope_initial;
			SEG_SECOND:  tan_sel = regs.slope_second;
			SEG_THIRD:   tan_sel = regs.slope_third;
			default:     tan_sel = regs.slope_last;
		endcase
	end

	always_comb begin
		val  = tot_s3;
		if (side_s3.zero) begin
			val = '0;
		end else if (side_s3.neg) begin
			val = -tot_s3;
		end
		fits = (val[SUM_W-1:STRESS_W-1] == '0) || (val[SUM_W-1:STRESS_W-1] == '1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.tangent <= TAN_W'(tan_sel);
			side_s1.seg     <= pop_data.seg;
			side_s1.neg     <= pop_data.neg;
			side_s1.zero    <= pop_data.zero;
			p0_s1 <= mul_slope(regs.slope_initial, pop_data.op0);
			p1_s1 <= mul_slope(regs.slope_second, pop_data.op1);
			p2_s1 <= mul_slope(regs.slope_third, pop_data.op2);
			p3_s1 <= mul_slope(regs.slope_last, pop_data.op3);

			side_s2 <= side_s1;
			pa_s2   <= sum_t'(p0_s1) + sum_t'(p1_s1);
			pb_s2   <= sum_t'(p2_s1) + sum_t'(p3_s1);

			side_s3 <= side_s2;
			tot_s3  <= pa_s2 + pb_s2;

			tan_s4 <= side_s3.tangent;
			seg_s4 <= side_s3.seg;
			ovf_s4 <= !fits;
			if (fits) begin
				stress_s4 <= val[STRESS_W-1:0];
			end else if (val[SUM_W-1]) begin
				stress_s4 <= STRESS_MIN;
			end else begin
				stress_s4 <= STRESS_MAX;
			end
		end
	end

	assign result.valid           = v_s4;
	assign result.tangent_modulus = tan_s4;
	assign result.stress          = stress_s4;
	assign result.segment         = seg_s4;
	assign result.overflow        = ovf_s4;

endmodule

FILE: verif/stress_law_checker.sv
module stress_law_checker (
	input  logic clk,
	input  logic arst_n,
	mss_in_if    sample,
	mss_out_if   result,
	mss_cfg_if   cfg,
	output int   mismatches,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import mss_pkg::*;

	localparam int AREA_W = 96;

	typedef logic signed [AREA_W-1:0] area_t;

	typedef struct packed {
		logic        [TAN_W-1:0]    tangent;
		logic signed [STRESS_W-1:0] stress;
		logic        [SEG_W-1:0]    seg;
		logic                       overflow;
	} law_out_t;

	cfg_t     law;
	law_out_t expected_q[$];

	function automatic law_out_t predict_law(input cfg_t c, input logic [STRAIN_W-1:0] x);
		area_t    mag;
		area_t    area;
		area_t    s0, s1, s2, s3;
		area_t    b1, b2, b3;
		law_out_t r;
		mag = $signed({{(AREA_W-STRAIN_W){x[STRAIN_W-1]}}, x});
		if (mag < 0)
			mag = -mag;
		s0 = AREA_W'(c.slope_initial);
		s1 = AREA_W'(c.slope_second);
		s2 = AREA_W'(c.slope_third);
		s3 = AREA_W'(c.slope_last);
		b1 = AREA_W'(c.break_first);
		b2 = AREA_W'(c.break_second);
		b3 = AREA_W'(c.break_third);
		r.overflow = 1'b0;
		// exact sum; spans of unordered breakpoints go negative
		if (mag < b1) begin
			r.seg     = SEG_INITIAL;
			r.tangent = c.slope_initial;
			area      = s0 * mag;
		end else begin
			area = s0 * b1;
			if (mag < b2) begin
				r.seg     = SEG_SECOND;
				r.tangent = c.slope_second;
				area      = area + s1 * (mag - b1);
			end else begin
				area = area + s1 * (b2 - b1);
				if (mag < b3) begin
					r.seg     = SEG_THIRD;
					r.tangent = c.slope_third;
					area      = area + s2 * (mag - b2);
				end else begin
					r.seg     = SEG_LAST;
					r.tangent = c.slope_last;
					area      = area + s2 * (b3 - b2) + s3 * (mag - b3);
				end
			end
		end
		if (mag == 0)
			area = '0;
		else if (x[STRAIN_W-1])
			area = -area;
		if (area > STRESS_MAX) begin
			r.overflow = 1'b1;
			r.stress   = STRESS_MAX;
		end else if (area < STRESS_MIN) begin
			r.overflow = 1'b1;
			r.stress   = STRESS_MIN;
		end else begin
			r.stress = area[STRESS_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		law_out_t want;
		if (!arst_n) begin
			law.slope_initial = SLOPE_RST;
			law.break_first   = BREAK_FIRST_RST;
			law.slope_second  = SLOPE_RST;
			law.break_second  = BREAK_SECOND_RST;
			law.slope_third   = SLOPE_RST;
			law.break_third   = BREAK_THIRD_RST;
			law.slope_last    = SLOPE_RST;
			expected_q.delete();
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result beat with no sample outstanding");
				end else begin
					want = expected_q.pop_front();
					if (result.tangent_modulus !== want.tangent)
						report_mismatch($sformatf("tangent_modulus %h, want %h",
							result.tangent_modulus, want.tangent));
					if (result.stress !== want.stress)
						report_mismatch($sformatf("stress %h, want %h",
							result.stress, want.stress));
					if (result.segment !== want.seg)
						report_mismatch($sformatf("segment %0d, want %0d",
							result.segment, want.seg));
					if (result.overflow !== want.overflow)
						report_mismatch($sformatf("overflow %b, want %b",
							result.overflow, want.overflow));
				end
			end
			if (sample.valid && sample.ready)
				expected_q.push_back(predict_law(law, sample.strain));
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_SLOPE_INITIAL: law.slope_initial = cfg.data[MOD_W-1:0];
					REG_BREAK_FIRST:   law.break_first   = cfg.data[BRK_W-1:0];
					REG_SLOPE_SECOND:  law.slope_second  = cfg.data[MOD_W-1:0];
					REG_BREAK_SECOND:  law.break_second  = cfg.data[BRK_W-1:0];
					REG_SLOPE_THIRD:   law.slope_third   = cfg.data[MOD_W-1:0];
					REG_BREAK_THIRD:   law.break_third   = cfg.data[BRK_W-1:0];
					REG_SLOPE_LAST:    law.slope_last    = cfg.data[MOD_W-1:0];
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end

endmodule

FILE: verif/tb_multilinear_stress_strain_core.sv
module tb_multilinear_stress_strain_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mss_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYCLES = 80;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending;
	int   cycles = 0;
	bit   tx_idle_en   = 1'b1;
	bit   rx_idle_en   = 1'b1;
	bit   hold_off_req = 1'b0;

	logic [BRK_W-1:0] brk [3];

	mss_in_if  sample_if ();
	mss_out_if result_if ();
	mss_cfg_if cfg_if ();

	multilinear_stress_strain_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	stress_law_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_if),
		.result     (result_if),
		.cfg        (cfg_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result backpressure: short random bursts, plus an occasional long hold
	initial begin
		int stall;
		stall = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall        = HOLD_CYCLES;
			end else if (stall == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 5);
			end
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				stall--;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	task automatic push_strain(input logic [STRAIN_W-1:0] v);
		sample_if.valid  <= 1'b1;
		sample_if.strain <= v;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_strain(input logic [STRAIN_W-1:0] v);
		push_strain(v);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			sample_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= d;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_law(input logic [31:0] s0, b1, s1, b2, s2, b3, s3);
		write_reg(REG_SLOPE_INITIAL, s0);
		write_reg(REG_BREAK_FIRST, b1);
		write_reg(REG_SLOPE_SECOND, s1);
		write_reg(REG_BREAK_SECOND, b2);
		write_reg(REG_SLOPE_THIRD, s2);
		write_reg(REG_BREAK_THIRD, b3);
		write_reg(REG_SLOPE_LAST, s3);
		write_reg(REG_UNUSED, $urandom);
		cfg_if.valid <= 1'b0;
		brk[0] = b1[BRK_W-1:0];
		brk[1] = b2[BRK_W-1:0];
		brk[2] = b3[BRK_W-1:0];
	endtask

	task automatic random_law(input int kind);
		logic [31:0] s [4];
		logic [31:0] b [3];
		foreach (s[i])
			s[i] = (kind == 0) ? $urandom_range(0, 1000) : $urandom;
		b[0] = $urandom_range(0, 32'h2000_0000);
		b[1] = b[0] + $urandom_range(0, 32'h2000_0000);
		b[2] = b[1] + $urandom_range(0, 32'h2000_0000);
		if (kind == 2) begin
			foreach (b[i])
				b[i] = $urandom;
		end
		if (kind == 3) begin
			foreach (s[i])
				s[i] = SLOPE_RST;
			b[0] = 32'(BREAK_FIRST_RST);
			b[1] = 32'(BREAK_SECOND_RST);
			b[2] = 32'(BREAK_THIRD_RST);
		end
		program_law(s[0], b[0], s[1], b[1], s[2], b[2], s[3]);
	endtask

	task automatic drain();
		sample_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (12)
			@(negedge clk);
	endtask

	function automatic logic [STRAIN_W-1:0] pick_strain();
		int unsigned          kind;
		logic [STRAIN_W-1:0] v;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			v = $urandom;
		end else if (kind <= 8) begin
			// straddle a breakpoint, or stay tiny
			if (kind == 8)
				v = $urandom_range(0, 255);
			else
				v = STRAIN_W'(brk[$urandom_range(0, 2)]) + STRAIN_W'($urandom_range(0, 6)) - 3;
			if ($urandom_range(0, 1))
				v = -v;
		end else begin
			case ($urandom_range(0, 4))
				0:       v = '0;
				1:       v = 32'h7FFF_FFFF;
				2:       v = 32'h8000_0000;
				3:       v = 32'h0000_0001;
				default: v = '1;
			endcase
		end
		return v;
	endfunction

	initial begin
		logic [STRAIN_W-1:0] reset_law_pts [] = '{
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd6553599, 32'd6553600,
			32'hFF9C_0000, 32'd13107199, 32'd13107200, 32'd19660799, 32'd19660800,
			32'hFED4_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001
		};
		logic [STRAIN_W-1:0] extreme_pts [] = '{
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0001,
			32'h0000_0000, 32'h7FFF_FFFE
		};
		sample_if.valid  <= 1'b0;
		sample_if.strain <= '0;
		cfg_if.valid     <= 1'b0;
		cfg_if.index     <= '0;
		cfg_if.data      <= '0;
		brk[0] = BREAK_FIRST_RST;
		brk[1] = BREAK_SECOND_RST;
		brk[2] = BREAK_THIRD_RST;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(negedge clk);

		foreach (reset_law_pts[i])
			send_strain(reset_law_pts[i]);
		drain();

		// unordered breakpoints, full slopes but a zero second slope: saturates both ways, bit 31 dropped
		program_law('1, '1, '0, '0, '1, '1, '1);
		foreach (extreme_pts[i])
			send_strain(extreme_pts[i]);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == PHASES - 1) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end else begin
				tx_idle_en = $urandom_range(0, 3) != 0;
				rx_idle_en = $urandom_range(0, 3) != 0;
			end
			if (phase == 0)
				program_law('0, '0, '0, '0, '0, '0, '0);
			else if (phase == PHASES - 2)
				program_law('1, 32'h2000_0000, '1, 32'h4000_0000, '1, 32'h7FFF_FFFF, '1);
			else
				random_law($urandom_range(0, 3));
			if (phase == 2 || phase == 6) begin
				tx_idle_en   = 1'b0;
				hold_off_req = 1'b1;
			end
			repeat (PHASE_ITEMS)
				send_strain(pick_strain());
			drain();
		end

		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
design/mss_pkg.sv
design/mss_intf.sv
design/mss_regs.sv
design/mss_front.sv
design/mss_queue.sv
design/mss_back.sv
design/multilinear_stress_strain_core.sv
verif/stress_law_checker.sv
verif/tb_multilinear_stress_strain_core.sv
